// ===== hdl/argb_alpha_over_blend_core_macros.svh =====
// Assertion macros for the ARGB source-over blend core.
// Used by the top level only; no other dependencies.
`ifndef ARGB_ALPHA_OVER_BLEND_CORE_MACROS_SVH
`define ARGB_ALPHA_OVER_BLEND_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define AOB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define AOB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/aob_pkg.sv =====
// Shared constants and types for the ARGB source-over blend core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package aob_pkg;

   // pipeline shape
   localparam int NUM_STAGES = 12;
   localparam int DIV_STEPS  = 8;
   localparam int NUM_LANES  = 3;
   localparam int CH_W       = 8;
   localparam int PROD_W     = 16;
   localparam int NUM_W      = 24;
   localparam int AOUT_DEPTH = NUM_STAGES - 2;

   // arithmetic constants
   localparam logic [CH_W-1:0]   FULL_ALPHA    = 8'hFF;
   localparam logic [CH_W-1:0]   CH_MAX        = 8'hFF;
   localparam logic [PROD_W-1:0] ROUND_HALF    = 16'd127;
   // floor(x / 255) == (x * 0x8081) >> 23 for any 16-bit x
   localparam logic [PROD_W-1:0] RECIP_255_Q23 = 16'h8081;
   // floor(x / 255) == (x * 0x808081) >> 31 for x up to 255^3
   localparam logic [NUM_W-1:0]  RECIP_255_Q31 = 24'h808081;

   typedef logic [NUM_STAGES:1] stage_vec_type;

   typedef struct packed {
      stage_vec_type adv;    // stage register loads this cycle
      stage_vec_type full;   // stage register holds a live item
   } pipe_ctl_type;

   // output alpha as it rides along stages 2 .. NUM_STAGES-1
   typedef logic [AOUT_DEPTH-1:0][CH_W-1:0] aout_line_type;

endpackage

`default_nettype wire

// ===== hdl/aob_ctrl.sv =====
// Pipeline occupancy and flow control for the blend core.
// Depends on aob_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aob_ctrl import aob_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         rsp_stall,
   output logic         req_stall,
   output logic         rsp_valid,
   output pipe_ctl_type ctl
);

   stage_vec_type valid_ff;
   stage_vec_type valid_in;
   stage_vec_type ready;

   // a stage loads on a free output or a hole at or after it
   for (genvar s = 1; s <= NUM_STAGES; s++) begin : g_ready
      assign ready[s] = ~rsp_stall | ~(&valid_ff[NUM_STAGES:s]);
   end

   // advance the valid bits, collapsing bubbles
   always_comb begin
      valid_in = valid_ff;
      if (ready[1]) begin
         valid_in[1] = req_valid;
      end
      for (int s = 2; s <= NUM_STAGES; s++) begin
         if (ready[s]) begin
            valid_in[s] = valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = ~ready[1];
   assign rsp_valid = valid_ff[NUM_STAGES];
   assign ctl.adv   = ready;
   assign ctl.full  = valid_ff;

endmodule

`default_nettype wire

// ===== hdl/aob_alpha.sv =====
// Output alpha path: Asrc + round(Adst * (255 - Asrc) / 255), then a delay
// line that feeds the colour lanes and the merge stage. Depends on aob_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aob_alpha import aob_pkg::*; (
   input  logic            clock,
   input  pipe_ctl_type    ctl,
   input  logic [CH_W-1:0] src_alpha,
   input  logic [CH_W-1:0] dst_alpha,
   output logic [CH_W-1:0] inv_alpha,
   output aout_line_type   aout_line
);

   logic [CH_W-1:0]     as_ff;
   logic [CH_W-1:0]     inv_ff;
   logic [PROD_W-1:0]   ai_ff;
   logic [CH_W-1:0]     inv_s0;
   logic [PROD_W-1:0]   biased;
   logic [2*PROD_W-1:0] recip_prod;
   logic [CH_W-1:0]     aout_in;
   aout_line_type       aout_ff;

   assign inv_s0 = FULL_ALPHA - src_alpha;

   // stage 1: weight the destination alpha
   always_ff @(posedge clock) begin
      if (ctl.adv[1]) begin
         as_ff  <= src_alpha;
         inv_ff <= inv_s0;
         ai_ff  <= PROD_W'(dst_alpha) * PROD_W'(inv_s0);
      end
   end

   // stage 2: round, divide by 255 through the reciprocal, add source alpha
   assign biased     = ai_ff + ROUND_HALF;
   assign recip_prod = {{PROD_W{1'b0}}, biased} * {{PROD_W{1'b0}}, RECIP_255_Q23};
   // the quotient never exceeds 255 - Asrc, so the sum stays in one byte
   assign aout_in    = as_ff + recip_prod[23 +: CH_W];

   // hold the output alpha beside the items in flight
   always_ff @(posedge clock) begin
      if (ctl.adv[2]) begin
         aout_ff[0] <= aout_in;
      end
      for (int j = 1; j < AOUT_DEPTH; j++) begin
         if (ctl.adv[2+j]) begin
            aout_ff[j] <= aout_ff[j-1];
         end
      end
   end

   assign inv_alpha = inv_ff;
   assign aout_line = aout_ff;

endmodule

`default_nettype wire

// ===== hdl/aob_lane.sv =====
// One colour lane: alpha-weighted sum, division by 255, then an eight-step
// pipelined restoring divide by the output alpha with saturation at 255.
// Depends on aob_pkg; fed by aob_alpha.
`timescale 1ns / 1ps
`default_nettype none

module aob_lane import aob_pkg::*; (
   input  logic            clock,
   input  pipe_ctl_type    ctl,
   input  logic [CH_W-1:0] src_ch,
   input  logic [CH_W-1:0] dst_ch,
   input  logic [CH_W-1:0] src_alpha,
   input  logic [CH_W-1:0] dst_alpha,
   input  logic [CH_W-1:0] inv_alpha,
   input  aout_line_type   aout_line,
   output logic [CH_W-1:0] ch_out
);

   localparam int DIV_BASE = 4;

   logic [PROD_W-1:0]  cs_as_ff;
   logic [PROD_W-1:0]  cd_ad_ff;
   logic [NUM_W-1:0]   weighted_src;
   logic [NUM_W-1:0]   weighted_dst;
   logic [NUM_W-1:0]   num_ff;
   logic [2*NUM_W-1:0] recip_prod;
   logic [PROD_W-1:0]  n2_ff;

   logic [DIV_STEPS-1:0][PROD_W-1:0] rem_stage;
   logic [DIV_STEPS-1:0][CH_W-1:0]   quo_stage;
   logic [DIV_STEPS-1:0]             sat_stage;

   // stage 1: per-pixel products
   always_ff @(posedge clock) begin
      if (ctl.adv[1]) begin
         cs_as_ff <= PROD_W'(src_ch) * PROD_W'(src_alpha);
         cd_ad_ff <= PROD_W'(dst_ch) * PROD_W'(dst_alpha);
      end
   end

   // stage 2: Cs*As*255 + Cd*Ad*(255-As)
   assign weighted_src = {cs_as_ff, {CH_W{1'b0}}} - {{CH_W{1'b0}}, cs_as_ff};
   assign weighted_dst = NUM_W'(cd_ad_ff) * NUM_W'(inv_alpha);

   always_ff @(posedge clock) begin
      if (ctl.adv[2]) begin
         num_ff <= weighted_src + weighted_dst;
      end
   end

   // stage 3: take out the factor of 255 from the divisor
   assign recip_prod = {{NUM_W{1'b0}}, num_ff} * {{NUM_W{1'b0}}, RECIP_255_Q31};

   always_ff @(posedge clock) begin
      if (ctl.adv[3]) begin
         n2_ff <= recip_prod[31 +: PROD_W];
      end
   end

   // stages 4..11: one quotient bit per stage, MSB first
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic [CH_W-1:0]   aout;
      logic [PROD_W-1:0] divisor;
      logic [PROD_W-1:0] rem_src;
      logic [CH_W-1:0]   quo_src;
      logic              sat_src;
      logic              take;
      logic [PROD_W-1:0] rem_ff;
      logic [CH_W-1:0]   quo_ff;
      logic              sat_ff;

      assign aout    = aout_line[k+1];
      assign divisor = PROD_W'(aout) << (DIV_STEPS - 1 - k);

      if (k == 0) begin : g_first
         // quotient above 255 exactly when n2 >= aout * 256
         assign rem_src = n2_ff;
         assign quo_src = '0;
         assign sat_src = (n2_ff >= {aout, {CH_W{1'b0}}});
      end else begin : g_next
         assign rem_src = rem_stage[k-1];
         assign quo_src = quo_stage[k-1];
         assign sat_src = sat_stage[k-1];
      end

      assign take = (rem_src >= divisor);

      always_ff @(posedge clock) begin
         if (ctl.adv[DIV_BASE+k]) begin
            rem_ff <= take ? (rem_src - divisor) : rem_src;
            quo_ff <= quo_src | (take ? (CH_W'(1) << (DIV_STEPS - 1 - k)) : '0);
            sat_ff <= sat_src;
         end
      end

      assign rem_stage[k] = rem_ff;
      assign quo_stage[k] = quo_ff;
      assign sat_stage[k] = sat_ff;
   end

   // clamp an overflowing quotient
   assign ch_out = sat_stage[DIV_STEPS-1] ? CH_MAX : quo_stage[DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== hdl/argb_alpha_over_blend_core.sv =====
// Source-over compositing of two straight-alpha ARGB 8888 pixels. The core
// takes one source/destination pair per clock while req_stall is low and
// returns one composited pixel per item, in order. Three colour lanes (red,
// green, blue) run side by side; each runs a pipelined restoring divider,
// one quotient bit per stage. A fully transparent source returns the
// destination pixel unchanged; a channel that would exceed 255 is clamped
// to 255. Stalls on the result side fill bubbles first, so the input side
// is held only when all 12 stages are occupied.
// Depends on aob_pkg, aob_ctrl, aob_alpha, aob_lane and the macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "argb_alpha_over_blend_core_macros.svh"

module argb_alpha_over_blend_core import aob_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_src_pixel,
   input  logic [31:0] req_dst_pixel,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_pixel
);

   localparam int LINE_LEN = NUM_STAGES - 1;
   localparam int ALPHA_LSB = NUM_LANES * CH_W;

   pipe_ctl_type                   ctl;
   logic [CH_W-1:0]                inv_alpha;
   aout_line_type                  aout_line;
   logic [NUM_LANES-1:0][CH_W-1:0] lane_ch;

   logic [LINE_LEN-1:0][31:0]      dst_line_ff;
   logic [LINE_LEN-1:0]            byp_line_ff;
   logic [31:0]                    out_ff;
   logic [31:0]                    out_in;
   logic                           byp_out_ff;

   // flow control
   aob_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .ctl       (ctl)
   );

   // output alpha
   aob_alpha u_alpha (
      .clock     (clock),
      .ctl       (ctl),
      .src_alpha (req_src_pixel[ALPHA_LSB +: CH_W]),
      .dst_alpha (req_dst_pixel[ALPHA_LSB +: CH_W]),
      .inv_alpha (inv_alpha),
      .aout_line (aout_line)
   );

   // colour lanes: blue, green, red
   for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
      aob_lane u_lane (
         .clock     (clock),
         .ctl       (ctl),
         .src_ch    (req_src_pixel[l*CH_W +: CH_W]),
         .dst_ch    (req_dst_pixel[l*CH_W +: CH_W]),
         .src_alpha (req_src_pixel[ALPHA_LSB +: CH_W]),
         .dst_alpha (req_dst_pixel[ALPHA_LSB +: CH_W]),
         .inv_alpha (inv_alpha),
         .aout_line (aout_line),
         .ch_out    (lane_ch[l])
      );
   end

   // carry the destination and the transparent-source flag alongside
   always_ff @(posedge clock) begin
      if (ctl.adv[1]) begin
         dst_line_ff[0] <= req_dst_pixel;
         byp_line_ff[0] <= (req_src_pixel[ALPHA_LSB +: CH_W] == '0);
      end
      for (int j = 1; j < LINE_LEN; j++) begin
         if (ctl.adv[1+j]) begin
            dst_line_ff[j] <= dst_line_ff[j-1];
            byp_line_ff[j] <= byp_line_ff[j-1];
         end
      end
   end

   // merge the lanes into one pixel, or pass the destination through
   assign out_in = byp_line_ff[LINE_LEN-1] ? dst_line_ff[LINE_LEN-1]
                                           : {aout_line[AOUT_DEPTH-1], lane_ch};

   always_ff @(posedge clock) begin
      if (ctl.adv[NUM_STAGES]) begin
         out_ff     <= out_in;
         byp_out_ff <= byp_line_ff[LINE_LEN-1];
      end
   end

   assign rsp_out_pixel = out_ff;

   // checks
   `AOB_ASSERT_IMPLY(a_stall_only_when_full, clock, reset, req_stall, (&ctl.full) && rsp_stall, "input held while a stage is empty")
   `AOB_ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && !req_stall, ctl.full[1], "accepted item lost at stage one")
   `AOB_ASSERT_NEXT(a_last_moves_out, clock, reset, ctl.full[NUM_STAGES-1] && !rsp_valid, rsp_valid, "item stuck before the output register")
   `AOB_ASSERT_IMPLY(a_blend_alpha_nonzero, clock, reset, rsp_valid && !byp_out_ff, rsp_out_pixel[31:24] != 8'd0, "blended item with zero alpha")

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for argb_alpha_over_blend_core: drives source/destination pixel
// pairs, predicts each source-over composite and checks every output pixel.
// Depends only on the core RTL and its package.
`timescale 1ns / 1ps

module tb;

   localparam int unsigned OPAQUE     = 255;
   localparam int unsigned HALF_UP    = 127;
   localparam int          DRAIN_WAIT = 24;
   localparam int          STUCK_MAX  = 4000;
   localparam int          HOLD_LEN   = 90;
   localparam int          IDLE_PCT   = 19;
   localparam int          SHOWN_MAX  = 10;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_src_pixel = '0;
   logic [31:0] req_dst_pixel = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_out_pixel;

   logic [31:0] expected_pixels[$];
   int          fault_count = 0;
   int          stuck_cycles = 0;
   int          hold_left = 0;
   bit          hold_start = 1'b0;
   bit          send_idle = 1'b0;
   bit          rsp_idle = 1'b0;

   argb_alpha_over_blend_core uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_src_pixel (req_src_pixel),
      .req_dst_pixel (req_dst_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_pixel (rsp_out_pixel)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Composite one pixel pair: source over destination, straight alpha
   function automatic logic [31:0] predict_over(input logic [31:0] src, input logic [31:0] dst);
      int unsigned a_s, a_d, inv, a_o, num, den, q;
      logic [31:0] res;
      a_s = 32'(src[31:24]);
      if (a_s == 0) return dst;
      a_d = 32'(dst[31:24]);
      inv = OPAQUE - a_s;
      a_o = a_s + (a_d * inv + HALF_UP) / OPAQUE;
      if (a_o > OPAQUE) a_o = OPAQUE;
      res = '0;
      res[31:24] = a_o[7:0];
      den = a_o * OPAQUE;
      for (int k = 0; k < 3; k++) begin
         num = 32'(src[8*k +: 8]) * a_s * OPAQUE + 32'(dst[8*k +: 8]) * a_d * inv;
         q = num / den;
         // clamp instead of wrapping
         if (q > OPAQUE) q = OPAQUE;
         res[8*k +: 8] = q[7:0];
      end
      return res;
   endfunction

   // Offer one pair, optionally after random gaps, and record its expected pixel
   task automatic send_pair(input logic [31:0] src, input logic [31:0] dst);
      if (send_idle) begin
         while ($urandom_range(0, 99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid     <= 1'b1;
      req_src_pixel <= src;
      req_dst_pixel <= dst;
      do @(posedge clock); while (req_stall);
      expected_pixels.push_back(predict_over(src, dst));
   endtask

   // Alpha biased toward its extremes
   function automatic logic [7:0] pick_alpha();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h01;
         3: return 8'hFE;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Colour channels, sometimes all dark or all bright
   function automatic logic [23:0] pick_colour();
      case ($urandom_range(0, 7))
         0: return 24'h000000;
         1: return 24'hFFFFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   // Transparent and opaque sources, extremes of every byte, clamped channels
   task automatic test_directed();
      send_pair(32'h00000000, 32'h00000000);
      send_pair(32'h00000000, 32'hFFFFFFFF);
      send_pair(32'h00FFFFFF, 32'h12345678);
      send_pair(32'h00ABCDEF, 32'hA5C3E1F0);
      send_pair(32'hFFFFFFFF, 32'h00000000);
      send_pair(32'hFF000000, 32'hFFFFFFFF);
      send_pair(32'hFF123456, 32'h80ABCDEF);
      send_pair(32'hFFFFFFFF, 32'hFFFFFFFF);
      send_pair(32'h01FFFFFF, 32'h00000000);
      send_pair(32'h01000000, 32'hFFFFFFFF);
      send_pair(32'h01FFFFFF, 32'hFF000000);
      send_pair(32'hFE000000, 32'hFFFFFFFF);
      send_pair(32'h80FF00FF, 32'h8000FF00);
      send_pair(32'h7F808080, 32'h7F7F7F7F);
      // quotient above 255 before the clamp
      send_pair(32'h02FFFFFF, 32'h40FFFFFF);
      send_pair(32'h02FF00FF, 32'h4000FF00);
      send_pair(32'hC8FFFFFF, 32'h01FFFFFF);
      send_pair(32'h01FFFFFF, 32'h80FFFFFF);
      send_pair(32'h55555555, 32'hAAAAAAAA);
      send_pair(32'hAAAAAAAA, 32'h55555555);
      send_pair(32'h10F0F0F0, 32'h00FFFFFF);
      send_pair(32'hF00F0F0F, 32'h0F000000);
   endtask

   // Fill the pipeline while the output side holds off for a long stretch
   task automatic test_backpressure();
      send_idle  = 1'b0;
      rsp_idle   = 1'b0;
      hold_start = 1'b1;
      for (int n = 0; n < 40; n++)
         send_pair({pick_alpha(), pick_colour()}, {pick_alpha(), pick_colour()});
   endtask

   // Random pairs: a quiet stretch first, then random gaps on both sides
   task automatic test_random_stream(input int count);
      for (int n = 0; n < count; n++) begin
         if (n == 400) begin
            send_idle = 1'b1;
            rsp_idle  = 1'b1;
         end
         if ($urandom_range(0, 9) == 0)
            send_pair($urandom, $urandom);
         else
            send_pair({pick_alpha(), pick_colour()}, {pick_alpha(), pick_colour()});
      end
   endtask

   // Drop valid and let the pipeline drain
   task automatic test_drain();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random_stream(1390);
      test_drain();
      if (fault_count == 0 && expected_pixels.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Drive the output stall: long hold-off on request, else random stalls
   always @(posedge clock) begin
      if (hold_start) begin
         hold_left  = HOLD_LEN;
         hold_start = 1'b0;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= rsp_idle && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // Compare each output item with the oldest expected pixel
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            fault_count++;
            if (fault_count <= SHOWN_MAX)
               $display("ERROR: unexpected output item %08h", rsp_out_pixel);
         end else begin
            if (rsp_out_pixel !== expected_pixels[0]) begin
               fault_count++;
               if (fault_count <= SHOWN_MAX)
                  $display("ERROR: out_pixel expected %08h actual %08h",
                           expected_pixels[0], rsp_out_pixel);
            end
            void'(expected_pixels.pop_front());
         end
      end
   end

   // Stop the run when no item moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_MAX) begin
         $display("ERROR: timeout, no item moved for %0d cycles", STUCK_MAX);
         $display("Verification failed");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

endmodule
